// ----- hdl/apl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package apl_pkg;

   localparam int COSINE_TABLE_BITS_DEF = 10;
   localparam int STATE_WIDTH_DEF = 24;

   localparam int OPB_W = 19;
   localparam int COS_W = 18;
   localparam int LFO_W = 18;
   localparam int ANGLE1_W = 20;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_INDEX_W-1:0] REG_POLE_RADIUS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LFO_SINE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LFO_COSINE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_ANGLE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SPAN_ANGLE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STAGE_RATIO = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_FEEDBACK_GAIN = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_MIX_DEPTH = 3'd7;

   localparam logic [15:0] POLE_RADIUS_RST = 16'd61382;
   localparam logic signed [17:0] LFO_SINE_RST = 18'sd4;
   localparam logic signed [17:0] LFO_COSINE_RST = 18'sd65536;
   localparam logic [15:0] BASE_ANGLE_RST = 16'd451;
   localparam logic [15:0] SPAN_ANGLE_RST = 16'd1183;
   localparam logic [15:0] STAGE_RATIO_RST = 16'd12288;
   localparam logic [16:0] FEEDBACK_GAIN_RST = 17'd32768;
   localparam logic [15:0] MIX_DEPTH_RST = 16'd32768;

   typedef struct packed {
      logic clr;
      logic neg;
      logic rnd13;
   } mac_ctl_type;

   // cosine over a quarter turn, p in 0..16384, result q1.16
   function automatic longint cos_quarter(longint p);
      longint x;
      longint x2;
      longint t;
      longint one;
      one = 64'sd1 <<< 30;
      x = (p * 64'sd6746518852) >>> 16;
      x2 = (x * x) >>> 30;
      t = one;
      t = one - ((x2 * t) >>> 30) / 132;
      t = one - ((x2 * t) >>> 30) / 90;
      t = one - ((x2 * t) >>> 30) / 56;
      t = one - ((x2 * t) >>> 30) / 30;
      t = one - ((x2 * t) >>> 30) / 12;
      t = one - ((x2 * t) >>> 30) / 2;
      t = (t + 64'sd8192) >>> 14;
      if (t < 0) begin
         t = 0;
      end else if (t > 65536) begin
         t = 65536;
      end
      return t;
   endfunction

   function automatic longint cos_entry(longint idx, int tb);
      longint a;
      longint q;
      longint p;
      longint v;
      a = (idx << (16 - tb)) & 64'sd65535;
      q = a >> 14;
      p = a & 64'sd16383;
      case (q)
         0: v = cos_quarter(p);
         1: v = -cos_quarter(16384 - p);
         2: v = -cos_quarter(p);
         default: v = cos_quarter(16384 - p);
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/apl_cos_rom.sv -----
`timescale 1ns / 1ps
`default_nettype none

module apl_cos_rom #(
   parameter int COSINE_TABLE_BITS = apl_pkg::COSINE_TABLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic [COSINE_TABLE_BITS-1:0]  idx,
   output logic signed [apl_pkg::COS_W-1:0]   cos_q
);
   import apl_pkg::*;

   localparam int DEPTH = 2 ** COSINE_TABLE_BITS;

   logic signed [COS_W-1:0] rom [DEPTH];
   logic signed [COS_W-1:0] cos_q_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_rom
      assign rom[i] = COS_W'(cos_entry(longint'(i), COSINE_TABLE_BITS));
   end

   always_ff @(posedge clock) begin
      cos_q_ff <= rom[idx];
   end

   assign cos_q = cos_q_ff;

endmodule
`default_nettype wire

// ----- hdl/apl_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

module apl_mac #(
   parameter int STATE_WIDTH = apl_pkg::STATE_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire apl_pkg::mac_ctl_type         ctl,
   input  wire logic signed [STATE_WIDTH+1:0] op_a,
   input  wire logic signed [apl_pkg::OPB_W-1:0] op_b,
   input  wire logic signed [STATE_WIDTH+7:0] init,
   output logic signed [STATE_WIDTH+7:0]     sum
);
   import apl_pkg::*;

   localparam int AW = STATE_WIDTH + 2;
   localparam int ACC_W = STATE_WIDTH + 8;
   localparam int PW = AW + OPB_W;

   logic signed [PW-1:0]    prod;
   logic signed [PW-1:0]    prod_rnd;
   logic signed [ACC_W-1:0] term;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] acc_ff;

   // product rounded half up, q.16 or q.13 scaling
   always_comb begin
      prod = PW'(op_a) * PW'(op_b);
      if (ctl.rnd13) begin
         prod_rnd = (prod + PW'(4096)) >>> 13;
      end else begin
         prod_rnd = (prod + PW'(32768)) >>> 16;
      end
      term = prod_rnd[ACC_W-1:0];
      acc_in = (ctl.clr ? init : acc_ff) + (ctl.neg ? -term : term);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in;
      end
   end

   assign sum = acc_in;

endmodule
`default_nettype wire

// ----- hdl/allpass_phaser_with_lfo_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// an accepted word passes through the steps R2 to Y1 in order; rsp_valid is registered at the end of Y1
// a new word is taken only in the idle state, after the previous word's steps; every step passes
// through the shared multiply-accumulate unit
// a finished word is held back while the previous one waits in rsp
// reset (synchronous): registers to defaults, oscillator and filter state zero
module allpass_phaser_with_lfo_core #(
   parameter int COSINE_TABLE_BITS = apl_pkg::COSINE_TABLE_BITS_DEF,
   parameter int STATE_WIDTH = apl_pkg::STATE_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic signed [15:0]               req_sample_in,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [15:0]                    rsp_sample_out,
   input  wire logic                             csr_wr_en,
   input  wire logic [apl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [apl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import apl_pkg::*;

   localparam int SW = STATE_WIDTH;
   localparam int SW1 = STATE_WIDTH + 1;
   localparam int SW2 = STATE_WIDTH + 2;
   localparam int ACC_W = STATE_WIDTH + 8;

   localparam logic signed [ACC_W-1:0] SW_MAX = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SW_MIN = {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] S18_MAX = {{(ACC_W-17){1'b0}}, {17{1'b1}}};
   localparam logic signed [ACC_W-1:0] S18_MIN = {{(ACC_W-17){1'b1}}, {17{1'b0}}};
   localparam logic signed [ACC_W-1:0] S16_MAX = {{(ACC_W-15){1'b0}}, {15{1'b1}}};
   localparam logic signed [ACC_W-1:0] S16_MIN = {{(ACC_W-15){1'b1}}, {15{1'b0}}};

   typedef enum logic [18:0] {
      ST_IDLE = 19'h00001,
      ST_R2   = 19'h00002,
      ST_SIN0 = 19'h00004,
      ST_SIN1 = 19'h00008,
      ST_COS0 = 19'h00010,
      ST_COS1 = 19'h00020,
      ST_A1   = 19'h00040,
      ST_A2   = 19'h00080,
      ST_T2   = 19'h00100,
      ST_F0   = 19'h00200,
      ST_F1   = 19'h00400,
      ST_F2   = 19'h00800,
      ST_T3   = 19'h01000,
      ST_G0   = 19'h02000,
      ST_G1   = 19'h04000,
      ST_W0   = 19'h08000,
      ST_W1   = 19'h10000,
      ST_Y0   = 19'h20000,
      ST_Y1   = 19'h40000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // configuration
   logic [15:0]              pole_radius_ff;
   logic signed [LFO_W-1:0]  lfo_sine_ff;
   logic signed [LFO_W-1:0]  lfo_cosine_ff;
   logic [15:0]              base_angle_ff;
   logic [15:0]              span_angle_ff;
   logic [15:0]              stage_ratio_ff;
   logic [16:0]              feedback_gain_ff;
   logic [15:0]              mix_depth_ff;

   // persistent state
   logic                     started_ff;
   logic signed [LFO_W-1:0]  lfo_sin_ff;
   logic signed [LFO_W-1:0]  lfo_cos_ff;
   logic signed [SW-1:0]     h1_0_ff;
   logic signed [SW-1:0]     h1_1_ff;
   logic signed [SW-1:0]     h2_0_ff;
   logic signed [SW-1:0]     h2_1_ff;
   logic signed [SW-1:0]     wet_fb_ff;

   // per-word intermediates
   logic signed [15:0]         x_ff;
   logic [16:0]                r2_ff;
   logic signed [LFO_W-1:0]    s_new_ff;
   logic signed [LFO_W-1:0]    c_new_ff;
   logic signed [ANGLE1_W-1:0] a1_ff;
   logic [15:0]                a2_ff;
   logic signed [SW:0]         t2_ff;
   logic signed [SW:0]         t3_ff;
   logic signed [SW-1:0]       f0_ff;
   logic signed [SW-1:0]       g0_ff;
   logic signed [SW-1:0]       wet_ff;

   logic                       rsp_valid_ff;
   logic signed [15:0]         rsp_sample_out_ff;

   mac_ctl_type                mac_ctl;
   logic signed [SW2-1:0]      op_a;
   logic signed [OPB_W-1:0]    op_b;
   logic signed [ACC_W-1:0]    acc_init;
   logic signed [ACC_W-1:0]    mac_sum;
   logic                       advance;

   logic signed [SW-1:0]       sum_sw;
   logic signed [LFO_W-1:0]    sum_18;
   logic signed [15:0]         sum_16;

   logic [COSINE_TABLE_BITS-1:0] rom_idx;
   logic signed [COS_W-1:0]      cos_q;
   logic [16:0]                  r2x;
   logic [16:0]                  dry_share;

   apl_mac #(
      .STATE_WIDTH(STATE_WIDTH)
   ) u_mac (
      .clock(clock),
      .en   (advance),
      .ctl  (mac_ctl),
      .op_a (op_a),
      .op_b (op_b),
      .init (acc_init),
      .sum  (mac_sum)
   );

   assign rom_idx = (state_ff == ST_A2) ? a1_ff[15:16-COSINE_TABLE_BITS]
                                        : a2_ff[15:16-COSINE_TABLE_BITS];

   apl_cos_rom #(
      .COSINE_TABLE_BITS(COSINE_TABLE_BITS)
   ) u_cos_rom (
      .clock(clock),
      .idx  (rom_idx),
      .cos_q(cos_q)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign advance = !((state_ff == ST_Y1) && rsp_valid_ff && !rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign r2x = {pole_radius_ff, 1'b0};
   assign dry_share = 17'd65536 - {1'b0, mix_depth_ff};

   // saturation of the running sum
   always_comb begin
      if (mac_sum > SW_MAX) begin
         sum_sw = SW_MAX[SW-1:0];
      end else if (mac_sum < SW_MIN) begin
         sum_sw = SW_MIN[SW-1:0];
      end else begin
         sum_sw = mac_sum[SW-1:0];
      end
      if (mac_sum > S18_MAX) begin
         sum_18 = S18_MAX[LFO_W-1:0];
      end else if (mac_sum < S18_MIN) begin
         sum_18 = S18_MIN[LFO_W-1:0];
      end else begin
         sum_18 = mac_sum[LFO_W-1:0];
      end
      if (mac_sum > S16_MAX) begin
         sum_16 = S16_MAX[15:0];
      end else if (mac_sum < S16_MIN) begin
         sum_16 = S16_MIN[15:0];
      end else begin
         sum_16 = mac_sum[15:0];
      end
   end

   // operand selection per step
   always_comb begin
      mac_ctl = '0;
      op_a = '0;
      op_b = '0;
      acc_init = '0;
      unique case (state_ff)
         ST_R2: begin
            mac_ctl.clr = 1'b1;
            op_a = SW2'($signed({1'b0, pole_radius_ff}));
            op_b = OPB_W'($signed({1'b0, pole_radius_ff}));
         end
         ST_SIN0: begin
            mac_ctl.clr = 1'b1;
            op_a = SW2'(lfo_cos_ff);
            op_b = OPB_W'(lfo_sine_ff);
         end
         ST_SIN1: begin
            op_a = SW2'(lfo_sin_ff);
            op_b = OPB_W'(lfo_cosine_ff);
         end
         ST_COS0: begin
            mac_ctl.clr = 1'b1;
            acc_init = started_ff ? '0 : ACC_W'(65536);
            op_a = SW2'(lfo_cos_ff);
            op_b = OPB_W'(lfo_cosine_ff);
         end
         ST_COS1: begin
            mac_ctl.neg = 1'b1;
            op_a = SW2'(lfo_sin_ff);
            op_b = OPB_W'(lfo_sine_ff);
         end
         ST_A1: begin
            mac_ctl.clr = 1'b1;
            acc_init = ACC_W'({1'b0, base_angle_ff});
            op_a = SW2'(20'sd65536 - 20'(s_new_ff));
            op_b = OPB_W'($signed({1'b0, span_angle_ff}));
         end
         ST_A2: begin
            mac_ctl.clr = 1'b1;
            mac_ctl.rnd13 = 1'b1;
            op_a = SW2'(a1_ff);
            op_b = OPB_W'($signed({1'b0, stage_ratio_ff}));
         end
         ST_T2: begin
            mac_ctl.clr = 1'b1;
            op_a = SW2'(h1_0_ff);
            op_b = OPB_W'(cos_q);
         end
         ST_F0: begin
            mac_ctl.clr = 1'b1;
            acc_init = ACC_W'(x_ff);
            op_a = SW2'(wet_fb_ff);
            op_b = OPB_W'($signed({1'b0, feedback_gain_ff}));
         end
         ST_F1: begin
            mac_ctl.neg = 1'b1;
            op_a = SW2'(h1_1_ff);
            op_b = OPB_W'($signed({1'b0, r2_ff}));
         end
         ST_F2: begin
            op_a = SW2'(t2_ff);
            op_b = OPB_W'($signed({1'b0, r2x}));
         end
         ST_T3: begin
            mac_ctl.clr = 1'b1;
            op_a = SW2'(h2_0_ff);
            op_b = OPB_W'(cos_q);
         end
         ST_G0: begin
            mac_ctl.clr = 1'b1;
            acc_init = ACC_W'(h1_1_ff);
            op_a = SW2'(SW1'(f0_ff) - SW1'(h2_1_ff));
            op_b = OPB_W'($signed({1'b0, r2_ff}));
         end
         ST_G1: begin
            mac_ctl.neg = 1'b1;
            op_a = SW2'(t2_ff) - SW2'(t3_ff);
            op_b = OPB_W'($signed({1'b0, r2x}));
         end
         ST_W0: begin
            mac_ctl.clr = 1'b1;
            mac_ctl.neg = 1'b1;
            acc_init = ACC_W'(h2_1_ff);
            op_a = SW2'(t3_ff);
            op_b = OPB_W'($signed({1'b0, r2x}));
         end
         ST_W1: begin
            op_a = SW2'(g0_ff);
            op_b = OPB_W'($signed({1'b0, r2_ff}));
         end
         ST_Y0: begin
            mac_ctl.clr = 1'b1;
            op_a = SW2'(wet_ff);
            op_b = OPB_W'($signed({1'b0, mix_depth_ff}));
         end
         ST_Y1: begin
            op_a = SW2'(x_ff);
            op_b = OPB_W'($signed({1'b0, dry_share}));
         end
         default: begin
         end
      endcase
   end

   // step sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_R2;
         ST_R2:   state_in = ST_SIN0;
         ST_SIN0: state_in = ST_SIN1;
         ST_SIN1: state_in = ST_COS0;
         ST_COS0: state_in = ST_COS1;
         ST_COS1: state_in = ST_A1;
         ST_A1:   state_in = ST_A2;
         ST_A2:   state_in = ST_T2;
         ST_T2:   state_in = ST_F0;
         ST_F0:   state_in = ST_F1;
         ST_F1:   state_in = ST_F2;
         ST_F2:   state_in = ST_T3;
         ST_T3:   state_in = ST_G0;
         ST_G0:   state_in = ST_G1;
         ST_G1:   state_in = ST_W0;
         ST_W0:   state_in = ST_W1;
         ST_W1:   state_in = ST_Y0;
         ST_Y0:   state_in = ST_Y1;
         ST_Y1:   if (advance) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pole_radius_ff <= POLE_RADIUS_RST;
         lfo_sine_ff <= LFO_SINE_RST;
         lfo_cosine_ff <= LFO_COSINE_RST;
         base_angle_ff <= BASE_ANGLE_RST;
         span_angle_ff <= SPAN_ANGLE_RST;
         stage_ratio_ff <= STAGE_RATIO_RST;
         feedback_gain_ff <= FEEDBACK_GAIN_RST;
         mix_depth_ff <= MIX_DEPTH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_POLE_RADIUS:   pole_radius_ff <= csr_wdata[15:0];
            REG_LFO_SINE:      lfo_sine_ff <= $signed(csr_wdata[17:0]);
            REG_LFO_COSINE:    lfo_cosine_ff <= $signed(csr_wdata[17:0]);
            REG_BASE_ANGLE:    base_angle_ff <= csr_wdata[15:0];
            REG_SPAN_ANGLE:    span_angle_ff <= csr_wdata[15:0];
            REG_STAGE_RATIO:   stage_ratio_ff <= csr_wdata[15:0];
            REG_FEEDBACK_GAIN: feedback_gain_ff <= csr_wdata[16:0];
            REG_MIX_DEPTH:     mix_depth_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // intermediates, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         x_ff <= req_sample_in;
      end
      if (advance) begin
         case (state_ff)
            ST_R2:   r2_ff <= mac_sum[16:0];
            ST_SIN1: s_new_ff <= sum_18;
            ST_COS1: c_new_ff <= sum_18;
            ST_A1:   a1_ff <= mac_sum[ANGLE1_W-1:0];
            ST_A2:   a2_ff <= mac_sum[15:0];
            ST_T2:   t2_ff <= mac_sum[SW:0];
            ST_F2:   f0_ff <= sum_sw;
            ST_T3:   t3_ff <= mac_sum[SW:0];
            ST_G1:   g0_ff <= sum_sw;
            ST_W1:   wet_ff <= sum_sw;
            default: begin
            end
         endcase
      end
   end

   // filter and oscillator state, committed on the last step
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         lfo_sin_ff <= '0;
         lfo_cos_ff <= '0;
         h1_0_ff <= '0;
         h1_1_ff <= '0;
         h2_0_ff <= '0;
         h2_1_ff <= '0;
         wet_fb_ff <= '0;
      end else if ((state_ff == ST_Y1) && advance) begin
         started_ff <= 1'b1;
         lfo_sin_ff <= s_new_ff;
         lfo_cos_ff <= c_new_ff;
         h1_1_ff <= h1_0_ff;
         h1_0_ff <= f0_ff;
         h2_1_ff <= h2_0_ff;
         h2_0_ff <= g0_ff;
         wet_fb_ff <= wet_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_Y1) && advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_Y1) && advance) begin
         rsp_sample_out_ff <= sum_16;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_R2))
      else $error("accepted word did not start the sequence");

   a_word_from_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_Y1))
      else $error("rsp word appeared without the final step");

   a_started_before_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> started_ff)
      else $error("rsp word present before oscillator start");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import apl_pkg::*;

   localparam int TAB_BITS = 10;
   localparam int ST_W = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_sample_out;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   allpass_phaser_with_lfo_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample_out(rsp_sample_out),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // register copies
   logic [15:0] m_radius, m_base, m_span, m_ratio, m_depth;
   logic [17:0] m_lfo_sin, m_lfo_cos;
   logic [16:0] m_fb_gain;

   // filter and oscillator state
   bit started;
   longint osc_sin, osc_cos;
   longint sec1_z[2], sec2_z[2];
   longint wet_prev;

   logic signed [15:0] pending_samples[$];
   logic signed [15:0] expected_out[$];
   int send_idle, rcv_idle, hold_off, errors, cycles;

   function automatic longint mq16(longint a, longint b);
      return (a * b + 64'sd32768) >>> 16;
   endfunction

   function automatic longint clamp(longint v, int bits);
      longint hi, lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   // polynomial cosine over a quarter turn of 16384 steps, q1.16
   function automatic longint quarter_cos(longint p);
      longint x, x2, t, one;
      longint dv[6];
      dv = '{132, 90, 56, 30, 12, 2};
      one = 64'sd1 <<< 30;
      x = (p * 64'sd6746518852) >>> 16;
      x2 = (x * x) >>> 30;
      t = one;
      for (int k = 0; k < 6; k++) t = one - ((x2 * t) >>> 30) / dv[k];
      t = (t + 64'sd8192) >>> 14;
      return t < 0 ? 0 : (t > 65536 ? 65536 : t);
   endfunction

   function automatic longint angle_cos(longint angle);
      logic [15:0] a;
      longint p;
      a = angle[15:0];
      a = (a >> (16 - TAB_BITS)) << (16 - TAB_BITS);
      p = a[13:0];
      case (a[15:14])
         2'd0: return quarter_cos(p);
         2'd1: return -quarter_cos(16384 - p);
         2'd2: return -quarter_cos(p);
         default: return quarter_cos(16384 - p);
      endcase
   endfunction

   function automatic logic signed [15:0] phase_sample(logic signed [15:0] xin);
      longint x, sn, cs, r, r2, r2x, s, c, a1, a2, c1, c2, f0, g0, t2, t3, wet, y;
      x = xin;
      sn = $signed(m_lfo_sin);
      cs = $signed(m_lfo_cos);
      r = m_radius;
      r2 = mq16(r, r);
      r2x = 2 * r;
      s = clamp(mq16(sn, osc_cos) + mq16(cs, osc_sin), 18);
      c = clamp((started ? 0 : 65536) + mq16(cs, osc_cos) - mq16(sn, osc_sin), 18);
      osc_sin = s;
      osc_cos = c;
      started = 1'b1;
      a1 = longint'(m_base) + mq16(longint'(m_span), 65536 - s);
      a2 = (a1 * longint'(m_ratio) + 4096) >>> 13;
      c1 = angle_cos(a1);
      c2 = angle_cos(a2);
      t2 = mq16(sec1_z[0], c1);
      f0 = clamp(x + mq16(longint'(m_fb_gain), wet_prev) - mq16(r2, sec1_z[1])
                 + mq16(r2x, t2), ST_W);
      t3 = mq16(sec2_z[0], c2);
      g0 = clamp(sec1_z[1] + mq16(r2, f0 - sec2_z[1]) - mq16(r2x, t2 - t3), ST_W);
      wet = clamp(sec2_z[1] - mq16(r2x, t3) + mq16(r2, g0), ST_W);
      y = clamp(mq16(longint'(m_depth), wet) + mq16(65536 - longint'(m_depth), x), 16);
      sec1_z[1] = sec1_z[0];
      sec1_z[0] = f0;
      sec2_z[1] = sec2_z[0];
      sec2_z[0] = g0;
      wet_prev = wet;
      return y[15:0];
   endfunction

   task automatic report_mismatch(logic signed [15:0] got, logic signed [15:0] want);
      $display("mismatch sample_out: got %0d expected %0d at cycle %0d", got, want, cycles);
      errors++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_out.push_back(phase_sample(req_sample_in));
         end
         if (!req_valid || req_ready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_valid <= 1'b1;
               req_sample_in <= pending_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_out.size() == 0) begin
               $display("unexpected word sample_out %0d at cycle %0d", rsp_sample_out, cycles);
               errors++;
            end else begin
               logic signed [15:0] want;
               want = expected_out.pop_front();
               if (rsp_sample_out !== want) report_mismatch(rsp_sample_out, want);
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_idle);
         end
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_POLE_RADIUS: m_radius = val[15:0];
         REG_LFO_SINE: m_lfo_sin = val[17:0];
         REG_LFO_COSINE: m_lfo_cos = val[17:0];
         REG_BASE_ANGLE: m_base = val[15:0];
         REG_SPAN_ANGLE: m_span = val[15:0];
         REG_STAGE_RATIO: m_ratio = val[15:0];
         REG_FEEDBACK_GAIN: m_fb_gain = val[16:0];
         default: m_depth = val[15:0];
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // kind 0 musical, 1 raw random bits, 2 all zero, 3 all ones
   task automatic load_settings(int kind);
      logic [CSR_DATA_W-1:0] v[8];
      for (int i = 0; i < 8; i++) begin
         case (kind)
            0: v[i] = '0;
            1: v[i] = CSR_DATA_W'($urandom);
            2: v[i] = '0;
            default: v[i] = '1;
         endcase
      end
      if (kind == 0) begin
         v[REG_POLE_RADIUS] = CSR_DATA_W'($urandom_range(65535, 40000));
         v[REG_LFO_SINE] = CSR_DATA_W'($urandom_range(2000));
         v[REG_LFO_COSINE] = CSR_DATA_W'(65536 - $urandom_range(40));
         v[REG_BASE_ANGLE] = CSR_DATA_W'($urandom_range(4000));
         v[REG_SPAN_ANGLE] = CSR_DATA_W'($urandom_range(8000));
         v[REG_STAGE_RATIO] = CSR_DATA_W'($urandom_range(40000));
         v[REG_FEEDBACK_GAIN] = CSR_DATA_W'($urandom_range(65536));
         v[REG_MIX_DEPTH] = CSR_DATA_W'($urandom_range(32768));
      end
      for (int i = 0; i < 8; i++) write_reg(CSR_INDEX_W'(i), v[i]);
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_phase(int n, int s_idle, int r_idle, bit stall);
      send_idle = s_idle;
      rcv_idle = r_idle;
      for (int i = 0; i < n; i++) pending_samples.push_back(pick_sample());
      if (stall) hold_off = 400;
      wait (pending_samples.size() == 0 && expected_out.size() == 0 && !req_valid);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      logic signed [15:0] directed[$];
      m_radius = POLE_RADIUS_RST;
      m_lfo_sin = LFO_SINE_RST;
      m_lfo_cos = LFO_COSINE_RST;
      m_base = BASE_ANGLE_RST;
      m_span = SPAN_ANGLE_RST;
      m_ratio = STAGE_RATIO_RST;
      m_fb_gain = FEEDBACK_GAIN_RST;
      m_depth = MIX_DEPTH_RST;
      started = 1'b0;
      osc_sin = 0;
      osc_cos = 0;
      sec1_z = '{0, 0};
      sec2_z = '{0, 0};
      wet_prev = 0;
      errors = 0;
      cycles = 0;
      hold_off = 0;
      send_idle = 0;
      rcv_idle = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // first word starts the oscillator; full-scale steps and impulses
      directed = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'sd1,
                   -16'sd1, 16'sh7fff, 16'sh8000, 16'sh5555, 16'shaaaa, 16'sd0, 16'sd0,
                   16'sd0, 16'sd0};
      foreach (directed[i]) pending_samples.push_back(directed[i]);
      wait (pending_samples.size() == 0 && expected_out.size() == 0 && !req_valid);
      repeat (SETTLE) @(posedge clock);

      // feedback above unity, depth and pole radius at full scale
      write_reg(REG_FEEDBACK_GAIN, 18'h1ffff);
      write_reg(REG_MIX_DEPTH, 18'hffff);
      write_reg(REG_POLE_RADIUS, 18'hffff);
      run_phase(8, 0, 0, 0);

      load_settings(0);
      run_phase(150, 20, 47, 0);
      load_settings(1);
      run_phase(120, 20, 47, 1);
      load_settings(2);
      run_phase(60, 20, 47, 0);
      load_settings(0);
      run_phase(150, 47, 20, 0);
      load_settings(3);
      run_phase(60, 47, 20, 0);
      load_settings(1);
      run_phase(120, 47, 20, 0);
      load_settings(0);
      run_phase(200, 0, 0, 0);
      load_settings(1);
      run_phase(100, 0, 0, 1);
      load_settings(0);
      run_phase(140, 0, 0, 0);

      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/apl_pkg.sv
hdl/apl_cos_rom.sv
hdl/apl_mac.sv
hdl/allpass_phaser_with_lfo_core.sv
sim/tb_top.sv
